### hdl/abcdq_pkg.sv
// ----------------------------------------------------------------------------
// abcdq_pkg: shared constants and types for the abc to dq phasor transform
// Fixed-point constants, CORDIC arctangent table and inter-module enables.
// ----------------------------------------------------------------------------
package abcdq_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned ANGLE_BITS      = 16;
  localparam int unsigned ZW              = ANGLE_BITS + 1;
  localparam int unsigned CORDIC_STEPS    = 16;
  localparam int unsigned QUARTER         = 1 << (ANGLE_BITS - 2);

  // sqrt(3) in Q2.14
  localparam logic signed [15:0] SQRT3_Q14 = 16'sd28378;

  // round(2^30 / (6 * K)), K the 16-step CORDIC gain
  localparam int unsigned         KC_BITS    = 27;
  localparam logic signed [KC_BITS:0] FINAL_GAIN = 28'sd108672146;
  localparam int unsigned         ROUND_SHIFT = 44;
  // low slice of the rotated vector that goes through the unsigned multiplier
  localparam int unsigned         LOW_BITS    = 18;

  typedef struct packed {
    logic sum;
    logic turn;
  } prep_en_t;

  typedef struct packed {
    logic mul;
    logic fin;
  } scale_en_t;

  // atan(2^-i) in binary-angle units, rounded
  function automatic logic signed [ZW-1:0] atan_of(input int unsigned i);
    logic signed [ZW-1:0] t;
    case (i)
      0:       t = ZW'(8192);
      1:       t = ZW'(4836);
      2:       t = ZW'(2555);
      3:       t = ZW'(1297);
      4:       t = ZW'(651);
      5:       t = ZW'(326);
      6:       t = ZW'(163);
      7:       t = ZW'(81);
      8:       t = ZW'(41);
      9:       t = ZW'(20);
      10:      t = ZW'(10);
      11:      t = ZW'(5);
      12:      t = ZW'(3);
      13:      t = ZW'(1);
      14:      t = ZW'(1);
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

### hdl/abcdq_prep.sv
// ----------------------------------------------------------------------------
// abcdq_prep: positive-sequence sum and quadrant pre-turn
// Stage 1 forms 6*2^14 times the positive-sequence phasor and the negated
// angle; stage 2 turns the vector by +/-90 degrees into CORDIC range.
// ----------------------------------------------------------------------------
module abcdq_prep #(
  parameter int unsigned SAMPLE_BITS = abcdq_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned CW          = SAMPLE_BITS + 19
) (
  input  logic                                 clk_i,
  input  abcdq_pkg::prep_en_t                  en_i,
  input  logic        [abcdq_pkg::ANGLE_BITS-1:0] angle_i,
  input  logic signed [SAMPLE_BITS-1:0]        a_re_i,
  input  logic signed [SAMPLE_BITS-1:0]        a_im_i,
  input  logic signed [SAMPLE_BITS-1:0]        b_re_i,
  input  logic signed [SAMPLE_BITS-1:0]        b_im_i,
  input  logic signed [SAMPLE_BITS-1:0]        c_re_i,
  input  logic signed [SAMPLE_BITS-1:0]        c_im_i,
  output logic signed [CW-1:0]                 x_o,
  output logic signed [CW-1:0]                 y_o,
  output logic signed [abcdq_pkg::ZW-1:0]      z_o
);
  import abcdq_pkg::*;

  localparam int unsigned W  = SAMPLE_BITS;
  localparam int unsigned XW = W + 17;
  localparam int unsigned PW = W + 16;

  logic signed [W+2:0]  sr_re, sr_im;
  logic signed [W:0]    df_re, df_im;
  logic signed [PW-1:0] pr_re, pr_im;
  logic signed [XW-1:0] x_d, y_d, x_q, y_q;
  logic [ANGLE_BITS-1:0] phi_d, phi_q;

  logic signed [CW-1:0] xe, ye, x2_d, y2_d;
  logic signed [ZW-1:0] ze, z2_d;

  always_comb begin
    sr_re = ((W+3)'(a_re_i) <<< 1) - (W+3)'(b_re_i) - (W+3)'(c_re_i);
    sr_im = ((W+3)'(a_im_i) <<< 1) - (W+3)'(b_im_i) - (W+3)'(c_im_i);
    df_re = (W+1)'(b_re_i) - (W+1)'(c_re_i);
    df_im = (W+1)'(b_im_i) - (W+1)'(c_im_i);
    pr_re = PW'(df_re) * PW'(SQRT3_Q14);
    pr_im = PW'(df_im) * PW'(SQRT3_Q14);
    x_d   = (XW'(sr_re) <<< 14) - XW'(pr_im);
    y_d   = (XW'(sr_im) <<< 14) + XW'(pr_re);
    phi_d = '0 - angle_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.sum) begin
      x_q   <= x_d;
      y_q   <= y_d;
      phi_q <= phi_d;
    end
  end

  always_comb begin
    xe   = CW'(x_q);
    ye   = CW'(y_q);
    ze   = ZW'($signed(phi_q));
    x2_d = xe;
    y2_d = ye;
    z2_d = ze;
    if (ze > $signed(ZW'(QUARTER))) begin
      x2_d = -ye;
      y2_d = xe;
      z2_d = ze - $signed(ZW'(QUARTER));
    end else if (ze < -$signed(ZW'(QUARTER))) begin
      x2_d = ye;
      y2_d = -xe;
      z2_d = ze + $signed(ZW'(QUARTER));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.turn) begin
      x_o <= x2_d;
      y_o <= y2_d;
      z_o <= z2_d;
    end
  end

endmodule

### hdl/abcdq_cordic_cell.sv
// ----------------------------------------------------------------------------
// abcdq_cordic_cell: one CORDIC rotation step
// Turns (x, y) by +/-atan(2^-STEP) toward zero residual angle, registered.
// ----------------------------------------------------------------------------
module abcdq_cordic_cell #(
  parameter int unsigned CW   = abcdq_pkg::SAMPLE_BITS_DEF + 19,
  parameter int unsigned STEP = 0
) (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic signed [CW-1:0]             x_i,
  input  logic signed [CW-1:0]             y_i,
  input  logic signed [abcdq_pkg::ZW-1:0]  z_i,
  output logic signed [CW-1:0]             x_o,
  output logic signed [CW-1:0]             y_o,
  output logic signed [abcdq_pkg::ZW-1:0]  z_o
);
  import abcdq_pkg::*;

  localparam logic signed [ZW-1:0] T = atan_of(STEP);

  logic signed [CW-1:0] dx, dy, x_d, y_d;
  logic signed [ZW-1:0] z_d;

  always_comb begin
    dx = y_i >>> STEP;
    dy = x_i >>> STEP;
    if (!z_i[ZW-1]) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - T;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + T;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o <= x_d;
      y_o <= y_d;
      z_o <= z_d;
    end
  end

endmodule

### hdl/abcdq_scale.sv
// ----------------------------------------------------------------------------
// abcdq_scale: gain correction, rounding and saturation
// Multiplies each component by the combined gain in two partial products,
// then rounds, shifts and clamps into the output register.
// ----------------------------------------------------------------------------
module abcdq_scale #(
  parameter int unsigned SAMPLE_BITS = abcdq_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned CW          = SAMPLE_BITS + 19
) (
  input  logic                          clk_i,
  input  abcdq_pkg::scale_en_t          en_i,
  input  logic signed [CW-1:0]          x_i,
  input  logic signed [CW-1:0]          y_i,
  output logic signed [SAMPLE_BITS-1:0] d_axis_o,
  output logic signed [SAMPLE_BITS-1:0] q_axis_o,
  output logic                          clipped_o
);
  import abcdq_pkg::*;

  localparam int unsigned W   = SAMPLE_BITS;
  localparam int unsigned HW  = CW - LOW_BITS;
  localparam int unsigned PLW = LOW_BITS + KC_BITS;
  localparam int unsigned PHW = HW + KC_BITS + 1;
  localparam int unsigned SW  = CW + KC_BITS + 1;
  localparam int unsigned RW  = SW - ROUND_SHIFT;

  localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  logic signed [CW-1:0]  v   [2];
  logic signed [W-1:0]   res [2];
  logic                  sat [2];

  assign v[0] = x_i;
  assign v[1] = y_i;

  for (genvar g = 0; g < 2; g++) begin : g_lane
    logic signed [HW-1:0]  vh;
    logic [LOW_BITS-1:0]   vl;
    logic signed [PHW-1:0] ph_d, ph_q;
    logic [PLW-1:0]        pl_d, pl_q;
    logic signed [SW-1:0]  acc;
    logic signed [RW-1:0]  r;

    always_comb begin
      vh   = v[g][CW-1:LOW_BITS];
      vl   = v[g][LOW_BITS-1:0];
      ph_d = PHW'(vh) * PHW'(FINAL_GAIN);
      pl_d = PLW'(vl) * PLW'(FINAL_GAIN[KC_BITS-1:0]);
    end

    always_ff @(posedge clk_i) begin
      if (en_i.mul) begin
        ph_q <= ph_d;
        pl_q <= pl_d;
      end
    end

    always_comb begin
      acc = (SW'(ph_q) <<< LOW_BITS) + SW'(pl_q) + (SW'(1) <<< (ROUND_SHIFT - 1));
      r   = RW'(acc >>> ROUND_SHIFT);
      // out of range when the bits above the sample sign disagree with it
      sat[g] = !((&r[RW-1:W-1]) || !(|r[RW-1:W-1]));
      if (!sat[g]) begin
        res[g] = r[W-1:0];
      end else if (r[RW-1]) begin
        res[g] = MINV;
      end else begin
        res[g] = MAXV;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.fin) begin
      d_axis_o  <= res[0];
      q_axis_o  <= res[1];
      clipped_o <= sat[0] || sat[1];
    end
  end

endmodule

### hdl/abc_to_dq_phasor_transform_unit.sv
// ----------------------------------------------------------------------------
// abc_to_dq_phasor_transform_unit: abc phasors to rotor dq frame
// Positive-sequence extraction, rotation by -theta in a 16-cell CORDIC chain,
// gain correction and saturation to the sample width.
// ----------------------------------------------------------------------------
// Pipeline: 2 prep stages, 16 CORDIC cells and 2 scale stages between word
//   accept and result valid.
// Throughput: one word per cycle while out_stall_i is low; a stage holds one
//   word, moved on once the next stage is empty or moving; bubbles close up.
// Reset: asynchronous, clears all stage valid flags; datapath is not reset.
// ----------------------------------------------------------------------------
module abc_to_dq_phasor_transform_unit #(
  parameter int unsigned SAMPLE_BITS = abcdq_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic        [abcdq_pkg::ANGLE_BITS-1:0] angle_i,
  input  logic signed [SAMPLE_BITS-1:0]        a_re_i,
  input  logic signed [SAMPLE_BITS-1:0]        a_im_i,
  input  logic signed [SAMPLE_BITS-1:0]        b_re_i,
  input  logic signed [SAMPLE_BITS-1:0]        b_im_i,
  input  logic signed [SAMPLE_BITS-1:0]        c_re_i,
  input  logic signed [SAMPLE_BITS-1:0]        c_im_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]        d_axis_o,
  output logic signed [SAMPLE_BITS-1:0]        q_axis_o,
  output logic                                 clipped_o
);
  import abcdq_pkg::*;

  localparam int unsigned W    = SAMPLE_BITS;
  localparam int unsigned CW   = W + 19;
  localparam int unsigned NST  = CORDIC_STEPS + 4;
  localparam int unsigned C0   = 2;                  // first CORDIC stage
  localparam int unsigned CL   = C0 + CORDIC_STEPS - 1; // last CORDIC stage

  localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  logic [NST-1:0] vld_q, vld_d;
  logic [NST:0]   rdy;

  logic signed [CW-1:0] cx [CORDIC_STEPS+1];
  logic signed [CW-1:0] cy [CORDIC_STEPS+1];
  logic signed [ZW-1:0] cz [CORDIC_STEPS+1];

  prep_en_t  prep_en;
  scale_en_t scale_en;

  // a stage loads when it is empty or its word moves on
  always_comb begin
    rdy[NST] = !out_stall_i;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign vld_d = {vld_q[NST-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_d[k];
        end
      end
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = vld_q[NST-1];

  assign prep_en.sum   = rdy[0];
  assign prep_en.turn  = rdy[1];
  assign scale_en.mul  = rdy[NST-2];
  assign scale_en.fin  = rdy[NST-1];

  abcdq_prep #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .CW          (CW)
  ) u_prep (
    .clk_i   (clk_i),
    .en_i    (prep_en),
    .angle_i (angle_i),
    .a_re_i  (a_re_i),
    .a_im_i  (a_im_i),
    .b_re_i  (b_re_i),
    .b_im_i  (b_im_i),
    .c_re_i  (c_re_i),
    .c_im_i  (c_im_i),
    .x_o     (cx[0]),
    .y_o     (cy[0]),
    .z_o     (cz[0])
  );

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    abcdq_cordic_cell #(
      .CW   (CW),
      .STEP (i)
    ) u_cell (
      .clk_i (clk_i),
      .en_i  (rdy[C0+i]),
      .x_i   (cx[i]),
      .y_i   (cy[i]),
      .z_i   (cz[i]),
      .x_o   (cx[i+1]),
      .y_o   (cy[i+1]),
      .z_o   (cz[i+1])
    );
  end

  abcdq_scale #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .CW          (CW)
  ) u_scale (
    .clk_i     (clk_i),
    .en_i      (scale_en),
    .x_i       (cx[CORDIC_STEPS]),
    .y_i       (cy[CORDIC_STEPS]),
    .d_axis_o  (d_axis_o),
    .q_axis_o  (q_axis_o),
    .clipped_o (clipped_o)
  );

  // input backs up only when every stage is full and the output is held
  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&vld_q && out_stall_i))
    else $error("input stalled with room in the pipeline");

  // CORDIC must have driven the residual angle close to zero
  a_residual : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[CL] |-> (cz[CORDIC_STEPS] > -$signed(ZW'(64)) &&
                   cz[CORDIC_STEPS] < $signed(ZW'(64))))
    else $error("CORDIC residual angle did not converge");

  // a clipped result sits on a rail
  a_clip_rail : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && clipped_o) |-> (d_axis_o == MAXV || d_axis_o == MINV ||
                                    q_axis_o == MAXV || q_axis_o == MINV))
    else $error("clipped flag without a saturated component");

  // a word held at the output keeps the last stage loaded
  a_hold_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(d_axis_o)))
    else $error("held output word lost");

endmodule

### sim/abcdq_dq_checker.sv
// ----------------------------------------------------------------------------
// abcdq_dq_checker: scoreboard for the abc to dq phasor transform
// Watches the input and output channels, computes the expected d/q word for
// every accepted phasor word and compares each accepted result, in order.
// ----------------------------------------------------------------------------
module abcdq_dq_checker #(
  parameter int unsigned SAMPLE_BITS = abcdq_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  input  logic                                    in_stall_i,
  input  logic        [abcdq_pkg::ANGLE_BITS-1:0] angle_i,
  input  logic signed [SAMPLE_BITS-1:0]           a_re_i,
  input  logic signed [SAMPLE_BITS-1:0]           a_im_i,
  input  logic signed [SAMPLE_BITS-1:0]           b_re_i,
  input  logic signed [SAMPLE_BITS-1:0]           b_im_i,
  input  logic signed [SAMPLE_BITS-1:0]           c_re_i,
  input  logic signed [SAMPLE_BITS-1:0]           c_im_i,
  input  logic                                    out_valid_i,
  input  logic                                    out_stall_i,
  input  logic signed [SAMPLE_BITS-1:0]           d_axis_i,
  input  logic signed [SAMPLE_BITS-1:0]           q_axis_i,
  input  logic                                    clipped_i,
  output int                                      fail_count_o,
  output int                                      pending_o,
  output int                                      checked_o,
  output int                                      clipped_seen_o
);

  localparam int unsigned ABITS     = abcdq_pkg::ANGLE_BITS;
  localparam longint      QTR_TURN  = longint'(1) <<< (ABITS - 2);
  localparam longint      ROOT3_Q14 = 28378;
  localparam longint      DQ_GAIN   = 108672146;
  localparam int          ROTATIONS = 16;

  localparam longint ATAN_BINANG [ROTATIONS] = '{
    8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0
  };

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] d_axis;
    logic signed [SAMPLE_BITS-1:0] q_axis;
    logic                          clipped;
  } dq_word_t;

  dq_word_t dq_expected_q [$];

  function automatic logic signed [SAMPLE_BITS-1:0] clamp_sample(input longint v,
                                                                 inout logic clip);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      v    = hi;
      clip = 1'b1;
    end
    if (v < lo) begin
      v    = lo;
      clip = 1'b1;
    end
    return v[SAMPLE_BITS-1:0];
  endfunction

  function automatic dq_word_t park_rotate(
    input logic        [ABITS-1:0]       ang,
    input logic signed [SAMPLE_BITS-1:0] ar, ai, br, bi, cr, ci
  );
    dq_word_t   w;
    logic [ABITS-1:0] phi_bits;
    longint     x, y, z, t, dx, dy, dv, qv;
    logic       clip;
    x = (2 * longint'(ar) - longint'(br) - longint'(cr)) * 16384
        - ROOT3_Q14 * (longint'(bi) - longint'(ci));
    y = (2 * longint'(ai) - longint'(bi) - longint'(ci)) * 16384
        + ROOT3_Q14 * (longint'(br) - longint'(cr));
    // rotate by -theta, phi taken as a signed binary angle
    phi_bits = '0 - ang;
    z = longint'($signed(phi_bits));
    if (z > QTR_TURN) begin
      t = x; x = -y; y = t; z = z - QTR_TURN;
    end else if (z < -QTR_TURN) begin
      t = x; x = y; y = -t; z = z + QTR_TURN;
    end
    for (int i = 0; i < ROTATIONS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - ATAN_BINANG[i];
      end else begin
        x = x + dx; y = y - dy; z = z + ATAN_BINANG[i];
      end
    end
    // gain correction with round half up
    dv = (x * DQ_GAIN + (longint'(1) <<< 43)) >>> 44;
    qv = (y * DQ_GAIN + (longint'(1) <<< 43)) >>> 44;
    clip      = 1'b0;
    w.d_axis  = clamp_sample(dv, clip);
    w.q_axis  = clamp_sample(qv, clip);
    w.clipped = clip;
    return w;
  endfunction

  always @(posedge clk_i) begin
    dq_word_t want;
    if (!rst_ni) begin
      fail_count_o   = 0;
      checked_o      = 0;
      clipped_seen_o = 0;
      dq_expected_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (dq_expected_q.size() == 0) begin
          $error("result word with no expectation: d_axis %0d q_axis %0d clipped %0d",
                 d_axis_i, q_axis_i, clipped_i);
          fail_count_o++;
        end else begin
          want = dq_expected_q.pop_front();
          checked_o++;
          if (clipped_i) clipped_seen_o++;
          if (d_axis_i !== want.d_axis) begin
            $error("d_axis mismatch: expected %0d, actual %0d", want.d_axis, d_axis_i);
            fail_count_o++;
          end
          if (q_axis_i !== want.q_axis) begin
            $error("q_axis mismatch: expected %0d, actual %0d", want.q_axis, q_axis_i);
            fail_count_o++;
          end
          if (clipped_i !== want.clipped) begin
            $error("clipped mismatch: expected %0d, actual %0d", want.clipped, clipped_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        dq_expected_q.insert(dq_expected_q.size(),
                             park_rotate(angle_i, a_re_i, a_im_i, b_re_i, b_im_i,
                                         c_re_i, c_im_i));
    end
    pending_o = dq_expected_q.size();
  end

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench top for abc_to_dq_phasor_transform_unit
// Drives directed and random phasor words with random gaps and output stalls;
// the checker beside the block predicts and compares every d/q result.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned SB         = abcdq_pkg::SAMPLE_BITS_DEF;
  localparam int unsigned AB         = abcdq_pkg::ANGLE_BITS;
  localparam int          RAND_WORDS = 1600;
  localparam int          IDLE_LIMIT = 4000;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic        [AB-1:0] angle_i     = '0;
  logic signed [SB-1:0] a_re_i      = '0;
  logic signed [SB-1:0] a_im_i      = '0;
  logic signed [SB-1:0] b_re_i      = '0;
  logic signed [SB-1:0] b_im_i      = '0;
  logic signed [SB-1:0] c_re_i      = '0;
  logic signed [SB-1:0] c_im_i      = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic signed [SB-1:0] d_axis_o;
  logic signed [SB-1:0] q_axis_o;
  logic                 clipped_o;

  int fail_count;
  int pending;
  int checked;
  int clipped_seen;
  int words_sent   = 0;
  int idle_cycles  = 0;
  bit send_gaps    = 1'b1;
  bit recv_gaps    = 1'b1;

  abc_to_dq_phasor_transform_unit #(.SAMPLE_BITS(SB)) i_dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o,
    .angle_i, .a_re_i, .a_im_i, .b_re_i, .b_im_i, .c_re_i, .c_im_i,
    .out_valid_o, .out_stall_i,
    .d_axis_o, .q_axis_o, .clipped_o
  );

  abcdq_dq_checker #(.SAMPLE_BITS(SB)) i_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o),
    .angle_i, .a_re_i, .a_im_i, .b_re_i, .b_im_i, .c_re_i, .c_im_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .d_axis_i(d_axis_o), .q_axis_i(q_axis_o), .clipped_i(clipped_o),
    .fail_count_o(fail_count), .pending_o(pending),
    .checked_o(checked), .clipped_seen_o(clipped_seen)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // no word moving for too long means the block hung
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_phasor(input logic [AB-1:0] ang,
                             input logic [SB-1:0] ar, ai, br, bi, cr, ci);
    int gap;
    gap = send_gaps ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    angle_i    <= ang;
    a_re_i     <= ar;
    a_im_i     <= ai;
    b_re_i     <= br;
    b_im_i     <= bi;
    c_re_i     <= cr;
    c_im_i     <= ci;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_sent++;
  endtask

  function automatic logic [SB-1:0] edge_sample();
    case ($urandom_range(0, 5))
      0:       return {1'b1, {(SB-1){1'b0}}};
      1:       return {1'b0, {(SB-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      4:       return SB'(1);
      default: return SB'($urandom);
    endcase
  endfunction

  function automatic logic [AB-1:0] edge_angle();
    case ($urandom_range(0, 11))
      0:       return AB'(0);
      1:       return AB'(1);
      2:       return AB'(16383);
      3:       return AB'(16384);
      4:       return AB'(16385);
      5:       return AB'(32767);
      6:       return AB'(32768);
      7:       return AB'(32769);
      8:       return AB'(49151);
      9:       return AB'(49152);
      10:      return AB'(49153);
      default: return AB'(65535);
    endcase
  endfunction

  // result side: random stall before each word, none in quiet stretches
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = recv_gaps ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  initial begin
    logic [SB-1:0] mx;
    logic [SB-1:0] mn;
    logic [SB-1:0] v [6];
    logic [AB-1:0] ang;
    int            amp;
    mx = {1'b0, {(SB-1){1'b1}}};
    mn = {1'b1, {(SB-1){1'b0}}};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes
    send_phasor(AB'(0), '0, '0, '0, '0, '0, '0);
    send_phasor(AB'(0), mx, mx, mx, mx, mx, mx);
    send_phasor(AB'(65535), mn, mn, mn, mn, mn, mn);
    send_phasor(AB'(32768), mn, mn, mx, mx, mx, mx);
    send_phasor(AB'(1), mx, mx, mn, mn, mn, mn);
    // balanced positive sequence at 0, 1/4, 1/2, 3/4 turn and just beside 1/4 and 3/4
    send_phasor(AB'(0),     mx, '0, -SB'(16384), -SB'(28378), -SB'(16384), SB'(28378));
    send_phasor(AB'(16384), mx, '0, -SB'(16384), -SB'(28378), -SB'(16384), SB'(28378));
    send_phasor(AB'(32768), mx, '0, -SB'(16384), -SB'(28378), -SB'(16384), SB'(28378));
    send_phasor(AB'(49152), mx, '0, -SB'(16384), -SB'(28378), -SB'(16384), SB'(28378));
    send_phasor(AB'(49151), mx, '0, -SB'(16384), -SB'(28378), -SB'(16384), SB'(28378));
    send_phasor(AB'(16385), mx, '0, -SB'(16384), -SB'(28378), -SB'(16384), SB'(28378));
    // saturation on d and on q, both signs
    send_phasor(AB'(8192),  mx, mx, mx, mn, mn, mx);
    send_phasor(AB'(8192),  mn, mn, mn, mx, mx, mn);
    send_phasor(AB'(57344), mx, mx, mx, mn, mn, mx);
    send_phasor(AB'(57344), mn, mn, mn, mx, mx, mn);
    // alternating bit patterns
    send_phasor(AB'(16'hAAAA), SB'(16'h5555), SB'(16'hAAAA), SB'(16'h5555),
                SB'(16'hAAAA), SB'(16'h5555), SB'(16'hAAAA));
    send_phasor(AB'(16'h5555), SB'(16'hAAAA), SB'(16'h5555), SB'(16'hAAAA),
                SB'(16'h5555), SB'(16'hAAAA), SB'(16'h5555));

    for (int n = 0; n < RAND_WORDS; n++) begin
      if (n % 100 == 0) begin
        send_gaps = ($urandom_range(0, 3) != 0);
        recv_gaps = ($urandom_range(0, 3) != 0);
      end
      ang = ($urandom_range(0, 4) == 0) ? edge_angle() : AB'($urandom);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          foreach (v[k]) v[k] = SB'($urandom);
        end
        5, 6, 7: begin
          amp = $urandom_range(1, 12000);
          foreach (v[k]) v[k] = SB'(int'($urandom_range(0, 2 * amp)) - amp);
        end
        default: begin
          foreach (v[k]) v[k] = edge_sample();
        end
      endcase
      send_phasor(ang, v[0], v[1], v[2], v[3], v[4], v[5]);
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Sent %0d phasor words, checked %0d d/q results, %0d of them clipped.",
             words_sent, checked, clipped_seen);
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### files.f
hdl/abcdq_pkg.sv
hdl/abcdq_prep.sv
hdl/abcdq_cordic_cell.sv
hdl/abcdq_scale.sv
hdl/abc_to_dq_phasor_transform_unit.sv
sim/abcdq_dq_checker.sv
sim/tb.sv
